[rtl/life_generation_step_torus_core_assert.svh]
// Assertion macros for the toroidal life generation core.
// Included by the top level; no other dependencies.
`ifndef LIFE_GENERATION_STEP_TORUS_CORE_ASSERT_SVH
`define LIFE_GENERATION_STEP_TORUS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define LGST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication, disabled while reset is asserted
`define LGST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define LGST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LGST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/lgst_pkg.sv]
// Shared types and constants for the toroidal life generation core.
// No dependencies; used by every module of the block but the grid memory.
`timescale 1ns / 1ps
`default_nettype none

package lgst_pkg;

    // Default grid limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Fixed field widths
    localparam int DATA_W    = 64;
    localparam int IDX_W     = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

    // Life rule: live on a 3x3 sum of BIRTH_SUM, or SURVIVE_SUM with a live center
    localparam logic [3:0] BIRTH_SUM   = 4'd3;
    localparam logic [3:0] SURVIVE_SUM = 4'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_STEP  = 2'd2
    } lgst_mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP_RD,
        ST_STEP_CP,
        ST_STEP_DRAIN
    } lgst_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  row_index;
        logic [DATA_W-1:0] row_cells;
    } lgst_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_cells;
        logic              index_error;
    } lgst_out_t;

    // Row engine controls
    typedef struct packed {
        logic shift;
        logic merge;
        logic copy;
    } lgst_eng_ctrl_t;

    // One cell's neighborhood: bit 0 left, bit 1 center, bit 2 right
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] down;
    } lgst_nbhd_t;

endpackage

`default_nettype wire

[rtl/life_generation_step_torus_core.sv]
// Top level of the toroidal life generation core: handshakes, sequencer, banks.
// Depends on lgst_pkg, lgst_grid_mem, lgst_row_engine and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "life_generation_step_torus_core_assert.svh"

// Toroidal Conway life (B3/S23) over a grid of up to MAX_ROWS by MAX_COLS cells,
// held as one row word per memory entry in two banks. Each request writes a row,
// reads a row or advances one generation, and yields exactly one result. After
// reset the block clears all MAX_ROWS rows of the active bank, one row per cycle,
// before it takes the first request. A row write, an out-of-range access or an
// unused mode is answered straight from idle; a row read passes through a read
// state, for the memory's registered read port. A generation streams rows through
// the single read port: height+2 reads feed a three-row window whose column lanes
// produce one new row per cycle, then the rows beyond the height are copied, for
// MAX_ROWS+2 reads in all, and the pipeline drains; the result appears when the
// new bank is in place. Configuration writes are always taken.
module life_generation_step_torus_core #(
    parameter int MAX_ROWS = lgst_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgst_pkg::MAX_COLS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire lgst_pkg::lgst_in_t                in_data,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      lgst_pkg::lgst_out_t               out_data,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [lgst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lgst_pkg::CFG_W-1:0]        cfg_data
);

    localparam int DATA_W = lgst_pkg::DATA_W;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ADDR_W = ROW_W + 1;
    localparam int DEPTH  = 2 * (2 ** ROW_W);
    localparam int CNT_W  = $clog2(MAX_ROWS + 2);
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);
    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int WID_W  = $clog2(MAX_COLS + 1);

    lgst_pkg::lgst_state_t state_reg;
    lgst_pkg::lgst_state_t state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  active_reg;
    logic                  active_next;

    logic [lgst_pkg::CFG_W-1:0] grid_height_reg;
    logic [lgst_pkg::CFG_W-1:0] grid_width_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    lgst_pkg::lgst_out_t   out_data_reg;
    lgst_pkg::lgst_out_t   out_data_next;
    logic                  out_load;

    logic [HGT_W-1:0]      h_eff;
    logic [ROW_W-1:0]      h_last;
    logic [WID_W-1:0]      w_eff;
    logic [CIDX_W-1:0]     w_last;
    logic [MAX_COLS-1:0]   col_mask;
    logic                  accept;
    logic                  idx_err;
    logic [ROW_W-1:0]      req_row;
    logic [CNT_W-1:0]      wrap_cnt;

    logic [ROW_W-1:0]      step_row;
    logic                  iss_valid;
    logic                  iss_write;
    logic                  iss_copy;
    logic [ROW_W-1:0]      iss_row;

    logic                  s1_valid_reg;
    logic                  s1_write_reg;
    logic                  s1_copy_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic                  s2_write_reg;
    logic                  s2_copy_reg;
    logic [ROW_W-1:0]      s2_row_reg;
    logic                  s3_write_reg;
    logic [ROW_W-1:0]      s3_row_reg;
    logic                  pipe_empty;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [MAX_COLS-1:0]   mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [MAX_COLS-1:0]   mem_rdata;
    logic [MAX_COLS-1:0]   merged_row;

    lgst_pkg::lgst_eng_ctrl_t eng_ctrl;

    // Clamp the configured height and width to their usable ranges
    always_comb
    begin
        if (grid_height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (32'(grid_height_reg) > 32'(MAX_ROWS))
        begin
            h_eff = HGT_W'(MAX_ROWS);
        end
        else
        begin
            h_eff = HGT_W'(grid_height_reg);
        end

        if (grid_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(grid_width_reg) > 32'(MAX_COLS))
        begin
            w_eff = WID_W'(MAX_COLS);
        end
        else
        begin
            w_eff = WID_W'(grid_width_reg);
        end

        for (int x = 0; x < MAX_COLS; x++)
        begin
            col_mask[x] = (32'(x) < 32'(w_eff));
        end
    end

    assign h_last   = ROW_W'(h_eff - HGT_W'(1));
    assign w_last   = CIDX_W'(w_eff - WID_W'(1));
    assign wrap_cnt = CNT_W'(h_eff) + CNT_W'(1);

    // Request handshake
    assign in_stall = (state_reg != lgst_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign idx_err  = (32'(in_data.row_index) >= 32'(h_eff));
    assign req_row  = ROW_W'(in_data.row_index);

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg <= lgst_pkg::GRID_DIM_RESET;
            grid_width_reg  <= lgst_pkg::GRID_DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lgst_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                lgst_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Source row of the current generation read
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            step_row = h_last;
        end
        else if (cnt_reg == wrap_cnt)
        begin
            step_row = '0;
        end
        else
        begin
            step_row = ROW_W'(cnt_reg - CNT_W'(1));
        end
    end

    // Tag each generation read with the row it will produce
    always_comb
    begin
        iss_valid = (state_reg == lgst_pkg::ST_STEP_RD) || (state_reg == lgst_pkg::ST_STEP_CP);
        iss_copy  = (state_reg == lgst_pkg::ST_STEP_CP);
        iss_write = iss_copy ||
                    ((state_reg == lgst_pkg::ST_STEP_RD) && (cnt_reg >= CNT_W'(2)));
        iss_row   = iss_copy ? ROW_W'(cnt_reg) : ROW_W'(cnt_reg - CNT_W'(2));
    end

    // Advance the generation pipeline: read data, window, merged row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_write_reg <= 1'b0;
            s2_write_reg <= 1'b0;
            s3_write_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= iss_valid;
            s1_write_reg <= iss_write;
            s2_write_reg <= s1_write_reg;
            s3_write_reg <= s2_write_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_copy_reg <= iss_copy;
        s1_row_reg  <= iss_row;
        s2_copy_reg <= s1_copy_reg;
        s2_row_reg  <= s1_row_reg;
        s3_row_reg  <= s2_row_reg;
    end

    assign pipe_empty = !s1_valid_reg && !s2_write_reg && !s3_write_reg;

    assign eng_ctrl.shift = s1_valid_reg;
    assign eng_ctrl.merge = s2_write_reg;
    assign eng_ctrl.copy  = s2_copy_reg;

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {1'b0, ROW_W'(cnt_reg)};
        mem_wdata = '0;
        if (state_reg == lgst_pkg::ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (s3_write_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = {~active_reg, s3_row_reg};
            mem_wdata = merged_row;
        end
        else if (accept && (in_data.mode == lgst_pkg::MODE_WRITE) && !idx_err)
        begin
            mem_we    = 1'b1;
            mem_waddr = {active_reg, req_row};
            mem_wdata = in_data.row_cells[MAX_COLS-1:0] & col_mask;
        end

        if (state_reg == lgst_pkg::ST_IDLE)
        begin
            mem_raddr = {active_reg, req_row};
        end
        else
        begin
            mem_raddr = {active_reg, iss_copy ? ROW_W'(cnt_reg) : step_row};
        end
    end

    // Sequencer: next state, counter and result loads
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        active_next   = active_reg;
        out_load      = 1'b0;
        out_data_next = '0;

        unique case (state_reg)
            lgst_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_ROWS - 1))
                begin
                    cnt_next   = '0;
                    state_next = lgst_pkg::ST_IDLE;
                end
            end
            lgst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.mode)
                        lgst_pkg::MODE_WRITE:
                        begin
                            out_load                  = 1'b1;
                            out_data_next.index_error = idx_err;
                        end
                        lgst_pkg::MODE_READ:
                        begin
                            if (idx_err)
                            begin
                                out_load                  = 1'b1;
                                out_data_next.index_error = 1'b1;
                            end
                            else
                            begin
                                state_next = lgst_pkg::ST_READ;
                            end
                        end
                        lgst_pkg::MODE_STEP:
                        begin
                            cnt_next   = '0;
                            state_next = lgst_pkg::ST_STEP_RD;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            lgst_pkg::ST_READ:
            begin
                out_load                 = 1'b1;
                out_data_next.read_cells = DATA_W'(mem_rdata & col_mask);
                state_next               = lgst_pkg::ST_IDLE;
            end
            lgst_pkg::ST_STEP_RD:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == wrap_cnt)
                begin
                    if (32'(h_eff) == 32'(MAX_ROWS))
                    begin
                        state_next = lgst_pkg::ST_STEP_DRAIN;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(h_eff);
                        state_next = lgst_pkg::ST_STEP_CP;
                    end
                end
            end
            lgst_pkg::ST_STEP_CP:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAX_ROWS - 1))
                begin
                    state_next = lgst_pkg::ST_STEP_DRAIN;
                end
            end
            lgst_pkg::ST_STEP_DRAIN:
            begin
                if (pipe_empty)
                begin
                    active_next = ~active_reg;
                    out_load    = 1'b1;
                    state_next  = lgst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lgst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lgst_pkg::ST_CLEAR;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    // Output register: hold while stalled, drop once taken
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lgst_grid_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MAX_COLS)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lgst_row_engine #(
        .MAX_COLS (MAX_COLS)
    ) u_row_engine (
        .clk        (clk),
        .ctrl       (eng_ctrl),
        .rd_row     (mem_rdata),
        .w_last     (w_last),
        .col_mask   (col_mask),
        .merged_row (merged_row)
    );

    // New generation rows land only in the inactive bank
    `LGST_ASSERT_IMP(a_step_dst_bank, clk, rst_n, s3_write_reg, mem_waddr[ROW_W] != active_reg)
    // The active bank swaps only at the end of a generation
    `LGST_ASSERT_NXT(a_bank_swap, clk, rst_n, state_reg != lgst_pkg::ST_STEP_DRAIN, $stable(active_reg))
    // A result appears only from idle, a read or a finished generation
    `LGST_ASSERT_IMP(a_result_src, clk, rst_n, $rose(out_valid_reg), ($past(state_reg) == lgst_pkg::ST_IDLE) || ($past(state_reg) == lgst_pkg::ST_READ) || ($past(state_reg) == lgst_pkg::ST_STEP_DRAIN))

endmodule

`default_nettype wire

[rtl/lgst_grid_mem.sv]
// Dual-bank grid storage: one write port, one read port with registered data.
// Depends on nothing; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module lgst_grid_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] grid_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            grid_mem[waddr] <= wdata;
        end
    end

    // Read one row, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= grid_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/lgst_lane.sv]
// One column lane: applies the B3/S23 rule to a cell's 3x3 neighborhood.
// Depends on lgst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgst_lane (
    input  wire lgst_pkg::lgst_nbhd_t nbhd,
    input  wire logic                 en,
    output      logic                 alive
);

    logic [3:0] sum;

    // Count live cells, the center included
    assign sum = 4'($countones(nbhd));

    // Birth or survival, only inside the active width
    assign alive = en && ((sum == lgst_pkg::BIRTH_SUM) ||
                          ((sum == lgst_pkg::SURVIVE_SUM) && nbhd.mid[1]));

endmodule

`default_nettype wire

[rtl/lgst_row_engine.sv]
// Row engine: three-row window, one lane per column and the row merge register.
// Depends on lgst_pkg and lgst_lane.
`timescale 1ns / 1ps
`default_nettype none

module lgst_row_engine #(
    parameter int MAX_COLS = lgst_pkg::MAX_COLS_DEF
) (
    input  wire logic                        clk,
    input  wire lgst_pkg::lgst_eng_ctrl_t    ctrl,
    input  wire logic [MAX_COLS-1:0]         rd_row,
    input  wire logic [$clog2(MAX_COLS)-1:0] w_last,
    input  wire logic [MAX_COLS-1:0]         col_mask,
    output      logic [MAX_COLS-1:0]         merged_row
);

    localparam int CIDX_W = $clog2(MAX_COLS);

    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] mid_reg;
    logic [MAX_COLS-1:0] down_reg;
    logic [MAX_COLS-1:0] lane_bits;
    logic [MAX_COLS-1:0] merged_reg;
    logic [MAX_COLS-1:0] merged_next;
    logic                up_last;
    logic                mid_last;
    logic                down_last;

    // Advance the row window by one row
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            up_reg   <= mid_reg;
            mid_reg  <= down_reg;
            down_reg <= rd_row;
        end
    end

    // Select the last active column for the left wrap of column zero
    assign up_last   = up_reg[w_last];
    assign mid_last  = mid_reg[w_last];
    assign down_last = down_reg[w_last];

    // Build one lane per column
    for (genvar x = 0; x < MAX_COLS; x++)
    begin : g_lane
        lgst_pkg::lgst_nbhd_t nbhd;

        if (x == 0)
        begin : g_left_wrap
            assign nbhd.up[0]   = up_last;
            assign nbhd.mid[0]  = mid_last;
            assign nbhd.down[0] = down_last;
        end
        else
        begin : g_left
            assign nbhd.up[0]   = up_reg[x-1];
            assign nbhd.mid[0]  = mid_reg[x-1];
            assign nbhd.down[0] = down_reg[x-1];
        end

        assign nbhd.up[1]   = up_reg[x];
        assign nbhd.mid[1]  = mid_reg[x];
        assign nbhd.down[1] = down_reg[x];

        if (x == MAX_COLS - 1)
        begin : g_right_wrap
            assign nbhd.up[2]   = up_reg[0];
            assign nbhd.mid[2]  = mid_reg[0];
            assign nbhd.down[2] = down_reg[0];
        end
        else
        begin : g_right
            logic wrap;
            assign wrap         = (w_last == CIDX_W'(x));
            assign nbhd.up[2]   = wrap ? up_reg[0]   : up_reg[x+1];
            assign nbhd.mid[2]  = wrap ? mid_reg[0]  : mid_reg[x+1];
            assign nbhd.down[2] = wrap ? down_reg[0] : down_reg[x+1];
        end

        lgst_lane u_lane (
            .nbhd  (nbhd),
            .en    (col_mask[x]),
            .alive (lane_bits[x])
        );
    end

    // Merge lane results, or pass the newest row through unchanged for a copy
    assign merged_next = ctrl.copy ? down_reg : lane_bits;

    always_ff @(posedge clk)
    begin
        if (ctrl.merge)
        begin
            merged_reg <= merged_next;
        end
    end

    assign merged_row = merged_reg;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the toroidal life generation core (B3/S23 rule).
// Drives row writes, row reads and generation steps through the request and
// reply channels and checks every reply against an in-bench grid model or a typed table entry; needs lgst_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int MODE_W    = lgst_pkg::MODE_W;
    localparam int IDX_W     = lgst_pkg::IDX_W;
    localparam int DATA_W    = lgst_pkg::DATA_W;
    localparam int CFG_W     = lgst_pkg::CFG_W;
    localparam int CFG_IDX_W = lgst_pkg::CFG_IDX_W;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int GRID_ROWS = lgst_pkg::MAX_ROWS_DEF;
    localparam int GRID_COLS = lgst_pkg::MAX_COLS_DEF;
    localparam logic [DATA_W-1:0] ALL_LIVE = '1;

    // One line of the directed part: a grid resize or a single request
    typedef struct packed {
        bit                  resize;
        logic [CFG_W-1:0]    height;
        logic [CFG_W-1:0]    width;
        lgst_pkg::lgst_in_t  req;
        bit                  typed;
        lgst_pkg::lgst_out_t reply;
    } warmup_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    lgst_pkg::lgst_in_t   in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    lgst_pkg::lgst_out_t  out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = lgst_pkg::CFG_GRID_HEIGHT;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Grid model: two banks, the live one, and the size registers
    logic [DATA_W-1:0] life_bank [2][GRID_ROWS];
    bit                live_bank;
    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  width_reg;

    lgst_pkg::lgst_out_t pending_replies [$];
    lgst_pkg::lgst_out_t oldest_reply;
    warmup_step_t        warmup_steps [$];
    int                  requests_sent = 0;
    int                  fault_count = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;
    int                  stall_left = 0;

    life_generation_step_torus_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Clamp a size register to the range the grid supports
    function automatic int eff_dim(logic [CFG_W-1:0] v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] cols_in_use();
        int w;
        w = eff_dim(width_reg, GRID_COLS);
        return (w >= DATA_W) ? ALL_LIVE : (ALL_LIVE >> (DATA_W - w));
    endfunction

    // Apply one request to the grid model and return the reply it yields
    function automatic lgst_pkg::lgst_out_t apply_life_request(lgst_pkg::lgst_in_t req);
        lgst_pkg::lgst_out_t reply;
        logic [DATA_W-1:0]   next_row;
        int                  h, w, sum, ny, nx;
        bit                  src;
        reply = '0;
        h = eff_dim(height_reg, GRID_ROWS);
        w = eff_dim(width_reg, GRID_COLS);
        src = live_bank;
        if (req.mode == lgst_pkg::MODE_WRITE || req.mode == lgst_pkg::MODE_READ)
        begin
            if (req.row_index >= h)
                reply.index_error = 1'b1;
            else if (req.mode == lgst_pkg::MODE_WRITE)
                life_bank[src][req.row_index] = req.row_cells & cols_in_use();
            else
                reply.read_cells = life_bank[src][req.row_index] & cols_in_use();
        end
        else if (req.mode == lgst_pkg::MODE_STEP)
        begin
            // Rows past the height carry over; the rest get the 3x3 rule with wrap
            for (int y = 0; y < GRID_ROWS; y++)
            begin
                next_row = life_bank[src][y];
                if (y < h)
                begin
                    next_row = '0;
                    for (int x = 0; x < w; x++)
                    begin
                        sum = 0;
                        for (int dy = 0; dy < 3; dy++)
                        begin
                            ny = (y + dy + h - 1) % h;
                            for (int dx = 0; dx < 3; dx++)
                            begin
                                nx = (x + dx + w - 1) % w;
                                sum += life_bank[src][ny][nx];
                            end
                        end
                        if (sum == lgst_pkg::BIRTH_SUM ||
                            (sum == lgst_pkg::SURVIVE_SUM && life_bank[src][y][x]))
                            next_row[x] = 1'b1;
                    end
                end
                life_bank[!src][y] = next_row;
            end
            live_bank = !src;
        end
        return reply;
    endfunction

    function automatic lgst_pkg::lgst_in_t make_request(logic [MODE_W-1:0] mode, int row,
                                                        logic [DATA_W-1:0] cells);
        lgst_pkg::lgst_in_t req;
        req.mode = mode;
        req.row_index = row[IDX_W-1:0];
        req.row_cells = cells;
        return req;
    endfunction

    // Row pattern with a spread of densities
    function automatic logic [DATA_W-1:0] random_row();
        logic [DATA_W-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_LIVE;
            2: return a & b & {$urandom, $urandom};
            3: return a | b;
            4: return 64'd1 << $urandom_range(0, 63);
            default: return a;
        endcase
    endfunction

    function automatic lgst_pkg::lgst_in_t noise_request();
        return make_request(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                            random_row());
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return CFG_W'($urandom_range(1, 3));
            2: return $urandom_range(0, 1) ? 7'd64 : 7'd127;
            3: return CFG_W'($urandom_range(65, 127));
            9: return CFG_W'($urandom_range(17, 64));
            default: return CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic warmup_step_t req_row(lgst_pkg::lgst_in_t req);
        warmup_step_t s;
        s = '0;
        s.req = req;
        return s;
    endfunction

    function automatic warmup_step_t typed_row(lgst_pkg::lgst_in_t req,
                                               logic [DATA_W-1:0] cells, logic err);
        warmup_step_t s;
        s = '0;
        s.req = req;
        s.typed = 1'b1;
        s.reply.read_cells = cells;
        s.reply.index_error = err;
        return s;
    endfunction

    function automatic warmup_step_t size_row(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w);
        warmup_step_t s;
        s = '0;
        s.resize = 1'b1;
        s.height = h;
        s.width = w;
        return s;
    endfunction

    // Present one request, hold it until taken, and record its reply
    task automatic issue_request(input lgst_pkg::lgst_in_t req, input bit typed,
                                 input lgst_pkg::lgst_out_t typed_reply);
        lgst_pkg::lgst_out_t predicted;
        int                  gap;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        predicted = apply_life_request(req);
        pending_replies.push_back(typed ? typed_reply : predicted);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // Slip a stray request in now and then
    task automatic issue_mixed(input lgst_pkg::lgst_in_t req);
        if ($urandom_range(0, 9) == 0)
            issue_request(noise_request(), 1'b0, '0);
        issue_request(req, 1'b0, '0);
    endtask

    // Wait for the block to drain, then write height and width back to back
    task automatic write_grid_size(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= lgst_pkg::CFG_GRID_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        height_reg = h;
        @(negedge clk);
        cfg_index <= lgst_pkg::CFG_GRID_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        width_reg = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver stalls in bursts, each started with stall_pct percent odds
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            stall_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Check each accepted reply against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: reply with no request pending: read_cells %h index_error %b",
                             $time, out_data.read_cells, out_data.index_error);
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (out_data.read_cells !== oldest_reply.read_cells ||
                    out_data.index_error !== oldest_reply.index_error)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"%0t: reply mismatch: read_cells exp %h got %h, ",
                                  "index_error exp %b got %b"},
                                 $time, oldest_reply.read_cells, out_data.read_cells,
                                 oldest_reply.index_error, out_data.index_error);
                end
            end
        end
    end

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int base, eh;
        for (int b = 0; b < 2; b++)
            for (int y = 0; y < GRID_ROWS; y++)
                life_bank[b][y] = '0;
        live_bank = 1'b0;
        height_reg = lgst_pkg::GRID_DIM_RESET;
        width_reg = lgst_pkg::GRID_DIM_RESET;

        // Directed part: reset state, field extremes, every mode, clamps, tiny grids
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_READ, 0, '0),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_READ, 63, ALL_LIVE),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 0, ALL_LIVE),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_READ, 0, '0),
                                         ALL_LIVE, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 63,
                                                      64'h8000_0000_0000_0001),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(MODE_UNUSED, 63, ALL_LIVE), '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_STEP, 63, ALL_LIVE),
                                         '0, 1'b0));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 0, '0)));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 63, '0)));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 1, '0)));
        // zero size clamps to a single cell
        warmup_steps.push_back(size_row(7'd0, 7'd0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 1, ALL_LIVE),
                                         '0, 1'b1));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 0, ALL_LIVE),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_READ, 0, '0),
                                         64'd1, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_STEP, 0, '0),
                                         '0, 1'b0));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 0, '0)));
        // oversize clamps to the full grid; rows past the old height come back
        warmup_steps.push_back(size_row(7'd127, 7'd127));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 63, '0)));
        // three by three torus, rows one and two filled
        warmup_steps.push_back(size_row(7'd3, 7'd3));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 1, 64'h7),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_WRITE, 2, ALL_LIVE),
                                         '0, 1'b0));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_READ, 63, '0),
                                         '0, 1'b1));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_STEP, 0, '0),
                                         '0, 1'b0));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 0, '0)));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 1, '0)));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 2, '0)));
        // full height, two columns
        warmup_steps.push_back(size_row(7'd65, 7'd2));
        warmup_steps.push_back(typed_row(make_request(lgst_pkg::MODE_STEP, 0, '0),
                                         '0, 1'b0));
        warmup_steps.push_back(req_row(make_request(lgst_pkg::MODE_READ, 63, '0)));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        gap_pct = 20;
        stall_pct = 20;
        foreach (warmup_steps[i])
        begin
            if (warmup_steps[i].resize)
                write_grid_size(warmup_steps[i].height, warmup_steps[i].width);
            else
                issue_request(warmup_steps[i].req, warmup_steps[i].typed,
                              warmup_steps[i].reply);
        end

        // Random phases: resize, then fill/step/read-back runs or plain noise
        base = requests_sent;
        while (requests_sent - base < RANDOM_REQUESTS)
        begin
            if (requests_sent - base >= RANDOM_REQUESTS * 9 / 10)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = 15 * $urandom_range(0, 2);
                stall_pct = 15 * $urandom_range(0, 2);
            end
            write_grid_size(pick_dim(), pick_dim());
            eh = eff_dim(height_reg, GRID_ROWS);
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(10, 60))
                    issue_request(noise_request(), 1'b0, '0);
            end
            else
            begin
                for (int y = 0; y < eh; y++)
                    issue_mixed(make_request(lgst_pkg::MODE_WRITE, y, random_row()));
                repeat ($urandom_range(1, 6))
                begin
                    issue_mixed(make_request(lgst_pkg::MODE_STEP, $urandom_range(0, 63),
                                             random_row()));
                    for (int y = 0; y < eh; y++)
                        issue_mixed(make_request(lgst_pkg::MODE_READ, y, random_row()));
                end
            end
        end

        // Drop valid, drain the owed replies, and allow a pipeline's worth of slack
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/lgst_pkg.sv
rtl/lgst_grid_mem.sv
rtl/lgst_lane.sv
rtl/lgst_row_engine.sv
rtl/life_generation_step_torus_core.sv
test/testbench.sv
